[design/erpt_pkg.sv]
// Shared types, register codes, CORDIC angle table and matrix microcode
// for the rigid point transform. No dependencies.
package erpt_pkg;

  localparam int TRIG_ITERATIONS_DEF = 16;
  localparam int ADDR_W = 5;
  localparam int MAT_STEPS = 14;

  localparam logic [2:0] REG_POS_X = 3'd0;
  localparam logic [2:0] REG_POS_Y = 3'd1;
  localparam logic [2:0] REG_POS_Z = 3'd2;
  localparam logic [2:0] REG_ANG_X = 3'd3;
  localparam logic [2:0] REG_ANG_Y = 3'd4;
  localparam logic [2:0] REG_ANG_Z = 3'd5;

  localparam logic [1:0] REQ_FWD_POINT = 2'd0;
  localparam logic [1:0] REQ_FWD_DIR   = 2'd1;
  localparam logic [1:0] REQ_INV_POINT = 2'd2;
  localparam logic [1:0] REQ_INV_DIR   = 2'd3;

  localparam logic [32:0] FULL_DEG    = 33'd23592960;
  localparam logic [32:0] QUARTER_DEG = 33'd5898240;
  localparam logic signed [33:0] CORDIC_GAIN = 34'sh026DD3B6A;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  localparam logic [2:0] OPD_SX = 3'd0;
  localparam logic [2:0] OPD_CX = 3'd1;
  localparam logic [2:0] OPD_SY = 3'd2;
  localparam logic [2:0] OPD_CY = 3'd3;
  localparam logic [2:0] OPD_SZ = 3'd4;
  localparam logic [2:0] OPD_CZ = 3'd5;
  localparam logic [2:0] OPD_T  = 3'd6;

  localparam logic [2:0] ACT_M_POS = 3'd0;
  localparam logic [2:0] ACT_M_NEG = 3'd1;
  localparam logic [2:0] ACT_T     = 3'd2;
  localparam logic [2:0] ACT_ACC   = 3'd3;
  localparam logic [2:0] ACT_M_ADD = 3'd4;
  localparam logic [2:0] ACT_M_SUB = 3'd5;

  typedef struct packed {
    logic [1:0]         req_type;
    logic signed [31:0] vec_x;
    logic signed [31:0] vec_y;
    logic signed [31:0] vec_z;
  } erpt_in_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic               saturated;
  } erpt_out_t;

  typedef struct packed {
    logic               derive;
    logic signed [31:0] ang_x;
    logic signed [31:0] ang_y;
    logic signed [31:0] ang_z;
  } erpt_ang_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } erpt_pos_t;

  typedef logic [8:0][31:0] erpt_mat_t;

  typedef struct packed {
    logic [2:0] opd_a;
    logic [2:0] opd_b;
    logic [2:0] act;
    logic [3:0] idx;
  } erpt_uop_t;

  function automatic logic [31:0] atan_deg(input logic [4:0] i);
    case (i)
      5'd0:  atan_deg = 32'd2949120;
      5'd1:  atan_deg = 32'd1740967;
      5'd2:  atan_deg = 32'd919879;
      5'd3:  atan_deg = 32'd466945;
      5'd4:  atan_deg = 32'd234379;
      5'd5:  atan_deg = 32'd117304;
      5'd6:  atan_deg = 32'd58666;
      5'd7:  atan_deg = 32'd29335;
      5'd8:  atan_deg = 32'd14668;
      5'd9:  atan_deg = 32'd7334;
      5'd10: atan_deg = 32'd3667;
      5'd11: atan_deg = 32'd1833;
      5'd12: atan_deg = 32'd917;
      5'd13: atan_deg = 32'd458;
      5'd14: atan_deg = 32'd229;
      5'd15: atan_deg = 32'd115;
      5'd16: atan_deg = 32'd57;
      5'd17: atan_deg = 32'd29;
      5'd18: atan_deg = 32'd14;
      5'd19: atan_deg = 32'd7;
      5'd20: atan_deg = 32'd4;
      5'd21: atan_deg = 32'd2;
      5'd22: atan_deg = 32'd1;
      default: atan_deg = 32'd0;
    endcase
  endfunction

  function automatic erpt_uop_t mat_uop(input logic [4:0] step);
    case (step)
      5'd0:  mat_uop = '{OPD_CY, OPD_CZ, ACT_M_POS, 4'd0};
      5'd1:  mat_uop = '{OPD_CY, OPD_SZ, ACT_M_NEG, 4'd1};
      5'd2:  mat_uop = '{OPD_SX, OPD_SY, ACT_T,     4'd0};
      5'd3:  mat_uop = '{OPD_T,  OPD_CZ, ACT_ACC,   4'd0};
      5'd4:  mat_uop = '{OPD_CX, OPD_SZ, ACT_M_ADD, 4'd3};
      5'd5:  mat_uop = '{OPD_T,  OPD_SZ, ACT_ACC,   4'd0};
      5'd6:  mat_uop = '{OPD_CX, OPD_CZ, ACT_M_SUB, 4'd4};
      5'd7:  mat_uop = '{OPD_SX, OPD_CY, ACT_M_NEG, 4'd5};
      5'd8:  mat_uop = '{OPD_CX, OPD_SY, ACT_T,     4'd0};
      5'd9:  mat_uop = '{OPD_T,  OPD_CZ, ACT_ACC,   4'd0};
      5'd10: mat_uop = '{OPD_SX, OPD_SZ, ACT_M_SUB, 4'd6};
      5'd11: mat_uop = '{OPD_T,  OPD_SZ, ACT_ACC,   4'd0};
      5'd12: mat_uop = '{OPD_SX, OPD_CZ, ACT_M_ADD, 4'd7};
      5'd13: mat_uop = '{OPD_CX, OPD_CY, ACT_M_POS, 4'd8};
      default: mat_uop = '{OPD_CX, OPD_CY, ACT_M_POS, 4'd8};
    endcase
  endfunction

endpackage

[design/euler_rigid_point_transform_unit.sv]
// Rigid point transform top level: an accepted start passes the v1_r, v2_r,
// v3_r and out_strobe_r valid registers to out_strobe; one item per cycle while
// busy is low, results cannot be stalled by the receiver. An angle write raises
// busy while the shared CORDIC and multiplier rebuild the matrix. Synchronous
// reset zeroes config registers and valid flags and sets the matrix to identity.
module euler_rigid_point_transform_unit import erpt_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  erpt_in_t          in_item,
  output logic              out_strobe,
  output erpt_out_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  erpt_pos_t pos;
  erpt_ang_t ang;
  erpt_mat_t mat;

  erpt_cfg_regs u_cfg (
    .clk, .rst_n, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .pos, .ang
  );

  erpt_rot_gen #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_rot (
    .clk, .rst_n, .ang, .busy, .mat
  );

  erpt_xform_pipe u_pipe (
    .clk, .rst_n, .in_valid(start & ~busy), .in_item, .pos, .mat,
    .out_strobe, .out_item
  );

endmodule

[design/erpt_cfg_regs.sv]
// Configuration register file: translation and Euler angles over the
// APB-style port. Depends on erpt_pkg.
module erpt_cfg_regs import erpt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output erpt_pos_t         pos,
  output erpt_ang_t         ang
);

  logic [31:0] pos_x_r, pos_y_r, pos_z_r;
  logic [31:0] ang_x_r, ang_y_r, ang_z_r;
  logic        derive_r;
  logic        wr;
  logic [2:0]  idx;

  assign wr     = psel & penable & pwrite;
  assign idx    = paddr[ADDR_W-1:2];
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_x_r  <= '0;
      pos_y_r  <= '0;
      pos_z_r  <= '0;
      ang_x_r  <= '0;
      ang_y_r  <= '0;
      ang_z_r  <= '0;
      derive_r <= 1'b0;
    end else begin
      derive_r <= wr && (idx == REG_ANG_X || idx == REG_ANG_Y || idx == REG_ANG_Z);
      if (wr) begin
        case (idx)
          REG_POS_X: pos_x_r <= pwdata;
          REG_POS_Y: pos_y_r <= pwdata;
          REG_POS_Z: pos_z_r <= pwdata;
          REG_ANG_X: ang_x_r <= pwdata;
          REG_ANG_Y: ang_y_r <= pwdata;
          REG_ANG_Z: ang_z_r <= pwdata;
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    case (idx)
      REG_POS_X: prdata = pos_x_r;
      REG_POS_Y: prdata = pos_y_r;
      REG_POS_Z: prdata = pos_z_r;
      REG_ANG_X: prdata = ang_x_r;
      REG_ANG_Y: prdata = ang_y_r;
      REG_ANG_Z: prdata = ang_z_r;
      default:   prdata = '0;
    endcase
  end

  assign pos = '{$signed(pos_x_r), $signed(pos_y_r), $signed(pos_z_r)};
  assign ang = '{derive_r, $signed(ang_x_r), $signed(ang_y_r), $signed(ang_z_r)};

endmodule

[design/erpt_rot_gen.sv]
// Rotation matrix generator: angle reduction, iterative CORDIC sine and
// cosine, and a shared multiplier sequenced over the matrix entries.
// Depends on erpt_pkg.
module erpt_rot_gen import erpt_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITERATIONS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  erpt_ang_t ang,
  output logic      busy,
  output erpt_mat_t mat
);

  localparam int NUM_ITER = (TRIG_ITERATIONS > 30) ? 30 : TRIG_ITERATIONS;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_ABS   = 3'd1;
  localparam logic [2:0] ST_MOD   = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_ITER  = 3'd4;
  localparam logic [2:0] ST_STORE = 3'd5;
  localparam logic [2:0] ST_MUL   = 3'd6;
  localparam logic [2:0] ST_ACC   = 3'd7;

  logic [2:0]         state_r;
  logic [1:0]         sel_r;
  logic [4:0]         step_r;
  logic               neg_r, negs_r, negc_r;
  logic [32:0]        m_r;
  logic signed [33:0] x_r, y_r;
  logic signed [31:0] z_r;
  logic signed [31:0] sx_r, cx_r, sy_r, cy_r, sz_r, cz_r, t_r, acc_r;
  logic signed [63:0] prod_r;
  erpt_mat_t          mat_r;

  logic signed [31:0] ang_cur;
  logic [32:0]        mod_sub;
  logic [32:0]        red;
  logic signed [33:0] dx, dy;
  logic signed [31:0] atan_s;
  logic signed [31:0] s_val, c_val;
  erpt_uop_t          uop;
  logic signed [31:0] opa, opb;
  logic signed [63:0] q_full;
  logic signed [31:0] q;

  function automatic logic signed [31:0] pick(input logic [2:0] code,
      input logic signed [31:0] sx, cx, sy, cy, sz, cz, t);
    case (code)
      OPD_SX:  pick = sx;
      OPD_CX:  pick = cx;
      OPD_SY:  pick = sy;
      OPD_CY:  pick = cy;
      OPD_SZ:  pick = sz;
      OPD_CZ:  pick = cz;
      default: pick = t;
    endcase
  endfunction

  always_comb begin
    case (sel_r)
      2'd0:    ang_cur = ang.ang_x;
      2'd1:    ang_cur = ang.ang_y;
      default: ang_cur = ang.ang_z;
    endcase
    mod_sub = FULL_DEG << (3'd7 - step_r[2:0]);
    red     = (neg_r && m_r != '0) ? FULL_DEG - m_r : m_r;
    dx      = y_r >>> step_r;
    dy      = x_r >>> step_r;
    atan_s  = $signed(atan_deg(step_r));
    s_val   = negs_r ? 32'(-y_r) : 32'(y_r);
    c_val   = negc_r ? 32'(-x_r) : 32'(x_r);
    uop     = mat_uop(step_r);
    opa     = pick(uop.opd_a, sx_r, cx_r, sy_r, cy_r, sz_r, cz_r, t_r);
    opb     = pick(uop.opd_b, sx_r, cx_r, sy_r, cy_r, sz_r, cz_r, t_r);
    q_full  = (prod_r + 64'sd536870912) >>> 30;
    q       = q_full[31:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r   <= '0;
      step_r  <= '0;
      for (int k = 0; k < 9; k++) begin
        mat_r[k] <= (k % 4 == 0) ? ONE_Q30 : 32'd0;
      end
    end else begin
      case (state_r)
        ST_IDLE: begin
          if (ang.derive) begin
            sel_r   <= '0;
            state_r <= ST_ABS;
          end
        end
        ST_ABS: begin
          neg_r   <= ang_cur[31];
          m_r     <= {1'b0, ang_cur[31] ? 32'(-ang_cur) : ang_cur};
          step_r  <= '0;
          state_r <= ST_MOD;
        end
        ST_MOD: begin
          if (m_r >= mod_sub) m_r <= m_r - mod_sub;
          step_r <= step_r + 5'd1;
          if (step_r == 5'd7) state_r <= ST_FOLD;
        end
        ST_FOLD: begin
          if (red < QUARTER_DEG) begin
            z_r <= $signed(red[31:0]); negs_r <= 1'b0; negc_r <= 1'b0;
          end else if (red < 2 * QUARTER_DEG) begin
            z_r <= $signed(32'(2 * QUARTER_DEG - red)); negs_r <= 1'b0; negc_r <= 1'b1;
          end else if (red < 3 * QUARTER_DEG) begin
            z_r <= $signed(32'(red - 2 * QUARTER_DEG)); negs_r <= 1'b1; negc_r <= 1'b1;
          end else begin
            z_r <= $signed(32'(FULL_DEG - red)); negs_r <= 1'b1; negc_r <= 1'b0;
          end
          x_r     <= CORDIC_GAIN;
          y_r     <= '0;
          step_r  <= '0;
          state_r <= ST_ITER;
        end
        ST_ITER: begin
          if (z_r >= 0) begin
            x_r <= x_r - dx;
            y_r <= y_r + dy;
            z_r <= z_r - atan_s;
          end else begin
            x_r <= x_r + dx;
            y_r <= y_r - dy;
            z_r <= z_r + atan_s;
          end
          step_r <= step_r + 5'd1;
          if (step_r == 5'(NUM_ITER - 1)) state_r <= ST_STORE;
        end
        ST_STORE: begin
          case (sel_r)
            2'd0: begin sx_r <= s_val; cx_r <= c_val; end
            2'd1: begin sy_r <= s_val; cy_r <= c_val; end
            default: begin sz_r <= s_val; cz_r <= c_val; end
          endcase
          step_r <= '0;
          if (sel_r == 2'd2) begin
            state_r <= ST_MUL;
          end else begin
            sel_r   <= sel_r + 2'd1;
            state_r <= ST_ABS;
          end
        end
        ST_MUL: begin
          prod_r  <= opa * opb;
          state_r <= ST_ACC;
        end
        ST_ACC: begin
          if (step_r == '0) mat_r[2] <= sy_r;
          case (uop.act)
            ACT_M_POS: mat_r[uop.idx] <= q;
            ACT_M_NEG: mat_r[uop.idx] <= -q;
            ACT_T:     t_r <= q;
            ACT_ACC:   acc_r <= q;
            ACT_M_ADD: mat_r[uop.idx] <= acc_r + q;
            ACT_M_SUB: mat_r[uop.idx] <= q - acc_r;
            default: ;
          endcase
          if (step_r == 5'(MAT_STEPS - 1)) begin
            state_r <= ST_IDLE;
          end else begin
            step_r  <= step_r + 5'd1;
            state_r <= ST_MUL;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign busy = (state_r != ST_IDLE) | ang.derive;
  assign mat  = mat_r;

endmodule

[design/erpt_xform_pipe.sv]
// Four-stage transform pipeline: offset, nine products, row sums, and
// rounding with translation and saturation. Depends on erpt_pkg.
module erpt_xform_pipe import erpt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  erpt_in_t  in_item,
  input  erpt_pos_t pos,
  input  erpt_mat_t mat,
  output logic      out_strobe,
  output erpt_out_t out_item
);

  logic               v1_r, v2_r, v3_r, out_strobe_r;
  logic               inv1_r, fpt1_r, fpt2_r, fpt3_r;
  logic signed [32:0] d1_r [3];
  logic signed [64:0] prod2_r [9];
  logic signed [65:0] acc3_r [3];
  erpt_out_t          out_item_r;

  logic signed [31:0] v [3];
  logic signed [31:0] p [3];
  logic signed [32:0] d_nxt [3];
  logic signed [64:0] prod_nxt [9];
  logic signed [65:0] acc_nxt [3];
  logic signed [65:0] rnd [3];
  logic signed [39:0] res [3];
  logic signed [31:0] clip [3];
  logic [2:0]         sat;
  logic               inv_in, sub_p;

  assign v[0] = in_item.vec_x;
  assign v[1] = in_item.vec_y;
  assign v[2] = in_item.vec_z;
  assign p[0] = pos.x;
  assign p[1] = pos.y;
  assign p[2] = pos.z;
  assign inv_in = (in_item.req_type == REQ_INV_POINT) || (in_item.req_type == REQ_INV_DIR);
  assign sub_p  = (in_item.req_type == REQ_INV_POINT);

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      d_nxt[j] = 33'(v[j]) - (sub_p ? 33'(p[j]) : 33'sd0);
    end
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        prod_nxt[3*i+j] = 65'($signed(inv1_r ? mat[3*j+i] : mat[3*i+j])) * 65'(d1_r[j]);
      end
    end
    for (int i = 0; i < 3; i++) begin
      acc_nxt[i] = 66'(prod2_r[3*i] >>> 2) + 66'(prod2_r[3*i+1] >>> 2)
                 + 66'(prod2_r[3*i+2] >>> 2);
    end
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (acc3_r[i] + 66'sd134217728) >>> 28;
      res[i] = 40'(rnd[i]) + (fpt3_r ? 40'(p[i]) : 40'sd0);
      if (res[i] > 40'sd2147483647) begin
        clip[i] = 32'sh7FFF_FFFF;
        sat[i]  = 1'b1;
      end else if (res[i] < -40'sd2147483648) begin
        clip[i] = 32'sh8000_0000;
        sat[i]  = 1'b1;
      end else begin
        clip[i] = res[i][31:0];
        sat[i]  = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= in_valid;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      out_strobe_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    inv1_r <= inv_in;
    fpt1_r <= (in_item.req_type == REQ_FWD_POINT);
    d1_r   <= d_nxt;
    fpt2_r <= fpt1_r;
    prod2_r <= prod_nxt;
    fpt3_r <= fpt2_r;
    acc3_r <= acc_nxt;
    out_item_r <= '{clip[0], clip[1], clip[2], |sat};
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

[design/erpt_checker.sv]
// Port-level checks for the rigid point transform, bound to the top level.
// Depends on erpt_pkg.
module erpt_checker import erpt_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              start,
  input logic              busy,
  input logic              out_strobe,
  input logic              psel,
  input logic              penable,
  input logic              pwrite,
  input logic [ADDR_W-1:0] paddr,
  input logic [31:0]       pwdata,
  input logic [31:0]       prdata
);

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##4 out_strobe) else $error("beat lost in pipeline");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(start && !busy, 4)) else $error("result without beat");

  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(psel && penable && pwrite &&
      (paddr[4:2] == REG_ANG_X || paddr[4:2] == REG_ANG_Y || paddr[4:2] == REG_ANG_Z)))
    else $error("busy without angle write");

  a_readback: assert property (@(posedge clk) disable iff (!rst_n)
    (psel && penable && pwrite && paddr[4:2] != 3'd6 && paddr[4:2] != 3'd7)
      ##1 (psel && !pwrite && paddr == $past(paddr)) |-> prdata == $past(pwdata))
    else $error("register readback mismatch");

endmodule

bind euler_rigid_point_transform_unit erpt_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_strobe, .psel, .penable, .pwrite,
  .paddr, .pwdata, .prdata
);
